/* rtl/core/erg_pkg.sv */
package erg_pkg;

	localparam int MAX_STEPS = 32;
	localparam int STEP_W    = $clog2(MAX_STEPS);
	localparam int LEN_W     = STEP_W + 1;
	localparam int NCELLS    = 2 * MAX_STEPS - 1;
	localparam int POS_W     = $clog2(NCELLS);
	localparam int GAIN_W    = 9;
	localparam int GRID_W    = 32;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(256);

	typedef enum logic [1:0] {
		MODE_BYPASS = 2'd0,
		MODE_GRID   = 2'd1,
		MODE_EUCLID = 2'd2
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_LENGTH   = 3'd1,
		REG_PULSES   = 3'd2,
		REG_ROTATION = 3'd3,
		REG_GRID     = 3'd4,
		REG_DEPTH    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] pulses;
	} erg_pat_t;

	typedef struct packed {
		logic             valid;
		logic             direct;
		logic             on;
		logic [POS_W-1:0] target;
		logic [LEN_W-1:0] bucket;
	} erg_item_t;

endpackage

/* rtl/core/erg_cell.sv */
module erg_cell
	import erg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [POS_W-1:0]      idx,
	input  erg_pat_t              pat,
	input  erg_item_t             item_in,
	output erg_item_t             item_out
);

	logic             valid_q;
	logic             direct_q;
	logic             on_q;
	logic [POS_W-1:0] target_q;
	logic [LEN_W-1:0] bucket_q;

	logic [LEN_W-1:0] sum;
	logic             wrap;
	logic [LEN_W-1:0] bucket_nxt;
	logic             on_nxt;

	always_comb begin
		sum        = item_in.bucket + pat.pulses;
		wrap       = (sum >= pat.len);
		bucket_nxt = wrap ? (sum - pat.len) : sum;
		on_nxt     = (!item_in.direct && (item_in.target == idx)) ? wrap : item_in.on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			direct_q <= item_in.direct;
			on_q     <= on_nxt;
			target_q <= item_in.target;
			bucket_q <= bucket_nxt;
		end
	end

	assign item_out = '{valid: valid_q, direct: direct_q, on: on_q,
		target: target_q, bucket: bucket_q};

endmodule

/* rtl/core/euclidean_rhythm_step_gate_top.sv */
// Rhythmic gain gate, one band: step index in, on/off state and target gain out.
// Request channel: in_valid / in_stall with step_index. Result channel:
// out_valid / out_stall with step_on and target_gain (Q1.8, 256 is unity).
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and a write lands at that edge. Write registers only while idle.
// Throughput is one request per cycle while the result is not stalled. The
// Euclidean pattern is walked by a row of 2*MAX_STEPS-1 bucket cells, one
// Bresenham step per cell, and every request passes the whole row whatever the
// mode, followed by the output register.
// When the receiver stalls a valid result, the whole row holds and in_stall
// rises in the same cycle; it falls as soon as the result is taken.
// Reset empties the row and the output register and loads the register
// defaults: grid mode, length 16, 8 pulses, no rotation, empty grid, full depth.
module euclidean_rhythm_step_gate_top
	import erg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [STEP_W-1:0] step_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              step_on,
	output logic [GAIN_W-1:0] target_gain,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	logic [1:0]        mode_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  pulses_q;
	logic [STEP_W-1:0] rotation_q;
	logic [GRID_W-1:0] grid_q;
	logic [GAIN_W-1:0] depth_q;

	logic              out_valid_q;
	logic              step_on_q;
	logic [GAIN_W-1:0] target_gain_q;

	logic              adv;
	logic [LEN_W-1:0]  len_eff;
	logic [LEN_W-1:0]  pulses_eff;
	logic              empty;
	logic [STEP_W-1:0] rot_eff;
	logic [GAIN_W-1:0] depth_eff;
	erg_pat_t          pat;
	erg_item_t         head;
	erg_item_t         chain [NCELLS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_GRID;
			length_q   <= LEN_W'(16);
			pulses_q   <= LEN_W'(8);
			rotation_q <= '0;
			grid_q     <= '0;
			depth_q    <= GAIN_UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_LENGTH:   length_q   <= cfg_data[LEN_W-1:0];
				REG_PULSES:   pulses_q   <= cfg_data[LEN_W-1:0];
				REG_ROTATION: rotation_q <= cfg_data[STEP_W-1:0];
				REG_GRID:     grid_q     <= cfg_data[GRID_W-1:0];
				REG_DEPTH:    depth_q    <= cfg_data[GAIN_W-1:0];
				default:      ;
			endcase
		end
	end

	// clamp the pattern and depth settings
	always_comb begin
		len_eff    = (length_q > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS) : length_q;
		pulses_eff = (pulses_q > len_eff) ? len_eff : pulses_q;
		empty      = (len_eff == '0) || (pulses_eff == '0);
		rot_eff    = ((rotation_q != '0) && ({1'b0, rotation_q} < len_eff)) ?
			rotation_q : '0;
		depth_eff  = (depth_q > GAIN_UNITY) ? GAIN_UNITY : depth_q;
	end

	assign pat = '{len: len_eff, pulses: pulses_eff};

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	always_comb begin
		head.valid  = in_valid;
		head.target = POS_W'(step_index) + POS_W'(rot_eff);
		head.bucket = '0;
		unique case (mode_q)
			MODE_GRID: begin
				head.direct = 1'b1;
				head.on     = grid_q[step_index];
			end
			MODE_EUCLID: begin
				head.direct = empty;
				head.on     = 1'b0;
			end
			default: begin
				head.direct = 1'b1;
				head.on     = 1'b1;
			end
		endcase
	end

	assign chain[0] = head;

	for (genvar g = 0; g < NCELLS; g++) begin : g_cell
		erg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.idx      (POS_W'(g)),
			.pat      (pat),
			.item_in  (chain[g]),
			.item_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[NCELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_on_q     <= chain[NCELLS].on;
			target_gain_q <= chain[NCELLS].on ? GAIN_UNITY : (GAIN_UNITY - depth_eff);
		end
	end

	assign out_valid   = out_valid_q;
	assign step_on     = step_on_q;
	assign target_gain = target_gain_q;

`ifndef ASSERT_OFF
	a_stall_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the output register");

	a_on_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_on) |-> (target_gain == GAIN_UNITY))
		else $error("on step without unity gain");

	a_row_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(chain[NCELLS].valid && adv) |=> out_valid)
		else $error("result from last cell lost");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
	import erg_pkg::*;

	localparam logic [1:0]       MODE_SPARE = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int               NUM_DIR    = 41;
	localparam int               NUM_PHASES = 8;
	localparam int               PHASE_ITEMS = 40;
	localparam int               FLOOD_ITEMS = 120;
	localparam int               HOLD_CYCLES = 300;
	localparam int               TAIL_CYCLES = 2 * MAX_STEPS + 16;

	typedef struct packed {
		logic              on;
		logic [GAIN_W-1:0] gain;
	} gate_result_t;

	typedef struct packed {
		logic              is_cfg;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
		logic [STEP_W-1:0] step;
		logic              typed;
		gate_result_t      res;
	} gate_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [STEP_W-1:0] step_index;
	logic              out_valid;
	logic              out_stall;
	logic              step_on;
	logic [GAIN_W-1:0] target_gain;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	logic [1:0]        m_mode;
	logic [5:0]        m_len;
	logic [5:0]        m_pulses;
	logic [4:0]        m_rot;
	logic [GRID_W-1:0] m_grid;
	logic [8:0]        m_depth;

	gate_result_t pending_gates[$];
	int           bad_count;
	bit           tx_quiet;
	bit           rx_quiet;
	bit           rx_hold;
	bit           hold_go;
	int           rx_wait;

	euclidean_rhythm_step_gate_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.step_index  (step_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.step_on     (step_on),
		.target_gain (target_gain),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic gate_result_t predict_gate(input logic [STEP_W-1:0] s);
		gate_result_t r;
		logic         lit;
		int           n;
		int           k;
		int           pos;
		int           acc;
		int           i;
		int           depth;
		if (m_mode == MODE_GRID) begin
			lit = m_grid[s];
		end else if (m_mode == MODE_EUCLID) begin
			n = (m_len > MAX_STEPS) ? MAX_STEPS : m_len;
			k = (m_pulses > n) ? n : m_pulses;
			lit = 1'b0;
			if (n != 0 && k != 0) begin
				pos = s % n;
				if (m_rot != 0 && m_rot < n)
					pos = (pos + m_rot) % n;
				acc = 0;
				for (i = 0; i <= pos; i++) begin
					acc += k;
					lit = 1'b0;
					if (acc >= n) begin
						acc -= n;
						lit = 1'b1;
					end
				end
			end
		end else begin
			r.on = 1'b1;
			r.gain = GAIN_UNITY;
			return r;
		end
		depth = (m_depth > 256) ? 256 : m_depth;
		r.on = lit;
		r.gain = lit ? GAIN_UNITY : GAIN_W'(256 - depth);
		return r;
	endfunction

	function automatic gate_row_t cfg_row(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] d);
		gate_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.index = idx;
		r.data = d;
		return r;
	endfunction

	function automatic gate_row_t step_row(input int s);
		gate_row_t r;
		r = '0;
		r.step = STEP_W'(s);
		return r;
	endfunction

	function automatic gate_row_t chk_row(input int s, input logic on,
			input int gain);
		gate_row_t r;
		r = '0;
		r.step = STEP_W'(s);
		r.typed = 1'b1;
		r.res.on = on;
		r.res.gain = GAIN_W'(gain);
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		bad_count++;
		if (bad_count <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// caller stands at a falling edge; returns at the next falling edge with valid held
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:     m_mode = d[1:0];
			REG_LENGTH:   m_len = d[5:0];
			REG_PULSES:   m_pulses = d[5:0];
			REG_ROTATION: m_rot = d[4:0];
			REG_GRID:     m_grid = d[GRID_W-1:0];
			REG_DEPTH:    m_depth = d[8:0];
			default:      ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_gates.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_step(input logic [STEP_W-1:0] s, input logic typed,
			input gate_result_t typed_res);
		int           gap;
		gate_result_t want;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		want = typed ? typed_res : predict_gate(s);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		step_index <= s;
		do @(posedge clk); while (in_stall);
		pending_gates.push_back(want);
	endtask

	always @(negedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		gate_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
			if (pending_gates.size() == 0) begin
				flag_mismatch($sformatf("unexpected result on=%0b gain=%0d",
					step_on, target_gain));
			end else begin
				want = pending_gates.pop_front();
				if (step_on !== want.on || target_gain !== want.gain)
					flag_mismatch($sformatf("expected on=%0b gain=%0d, got on=%0b gain=%0d",
						want.on, want.gain, step_on, target_gain));
			end
		end
	end

	// long receiver hold-off so the row fills and the input stalls
	initial begin
		wait (hold_go);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		gate_row_t    dir_rows [NUM_DIR];
		bit           cfg_open;
		int           p;
		int           j;
		int           pick;
		int           n_items;
		int           len;
		logic [1:0]   mode;
		logic [DATA_W-1:0] v;

		arst_n = 1'b0;
		in_valid = 1'b0;
		step_index = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		bad_count = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 1'b0;
		hold_go = 1'b0;
		rx_wait = 0;
		m_mode = MODE_GRID;
		m_len = 6'd16;
		m_pulses = 6'd8;
		m_rot = '0;
		m_grid = '0;
		m_depth = 9'd256;

		dir_rows = '{
			chk_row(0, 1'b0, 0),
			chk_row(31, 1'b0, 0),
			cfg_row(REG_GRID, 32'h8000_0001),
			chk_row(0, 1'b1, 256),
			chk_row(31, 1'b1, 256),
			chk_row(15, 1'b0, 0),
			cfg_row(REG_DEPTH, 32'd0),
			chk_row(15, 1'b0, 256),
			cfg_row(REG_DEPTH, 32'd511),
			chk_row(1, 1'b0, 0),
			cfg_row(REG_DEPTH, 32'd64),
			chk_row(1, 1'b0, 192),
			cfg_row(REG_MODE, {30'd0, MODE_BYPASS}),
			chk_row(5, 1'b1, 256),
			cfg_row(REG_MODE, {30'd0, MODE_SPARE}),
			chk_row(7, 1'b1, 256),
			cfg_row(REG_MODE, {30'd0, MODE_EUCLID}),
			chk_row(1, 1'b1, 256),
			chk_row(0, 1'b0, 192),
			cfg_row(REG_PULSES, 32'd0),
			chk_row(1, 1'b0, 192),
			cfg_row(REG_PULSES, 32'd40),
			chk_row(0, 1'b1, 256),
			cfg_row(REG_LENGTH, 32'd0),
			chk_row(3, 1'b0, 192),
			cfg_row(REG_LENGTH, 32'd63),
			chk_row(31, 1'b1, 256),
			cfg_row(REG_LENGTH, 32'd5),
			cfg_row(REG_PULSES, 32'd2),
			cfg_row(REG_ROTATION, 32'd3),
			step_row(31),
			step_row(4),
			step_row(2),
			cfg_row(REG_ROTATION, 32'd5),
			step_row(2),
			cfg_row(REG_LENGTH, 32'd32),
			cfg_row(REG_PULSES, 32'd1),
			cfg_row(REG_ROTATION, 32'd31),
			step_row(0),
			step_row(30),
			cfg_row(REG_UNUSED, 32'hFFFF_FFFF)
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_open = 1'b0;
		for (j = 0; j < NUM_DIR; j++) begin
			if (dir_rows[j].is_cfg) begin
				if (!cfg_open)
					drain();
				cfg_open = 1'b1;
				write_reg(dir_rows[j].index, dir_rows[j].data);
			end else begin
				if (cfg_open)
					cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				send_step(dir_rows[j].step, dir_rows[j].typed, dir_rows[j].res);
			end
		end
		if (!cfg_open)
			drain();
		write_reg(REG_DEPTH, 32'd300);
		cfg_valid <= 1'b0;
		send_step(STEP_W'(9), 1'b0, '0);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p % 4)
				0, 2: mode = MODE_EUCLID;
				1:    mode = MODE_GRID;
				default: mode = 2'($urandom_range(0, 3));
			endcase
			write_reg(REG_MODE, {30'd0, mode});

			pick = $urandom_range(0, 9);
			if (pick == 0)      len = 0;
			else if (pick == 1) len = $urandom_range(33, 63);
			else if (pick == 2) len = 32;
			else if (pick == 3) len = 1;
			else                len = $urandom_range(1, 32);
			write_reg(REG_LENGTH, DATA_W'(len));

			pick = $urandom_range(0, 9);
			if (pick == 0)      v = 0;
			else if (pick < 3)  v = $urandom_range(0, 63);
			else                v = $urandom_range(1, (len > 32) ? 32 : (len < 1 ? 1 : len));
			write_reg(REG_PULSES, v);

			if (len >= 2 && len <= 32 && $urandom_range(0, 2) != 0)
				v = $urandom_range(0, len - 1);
			else
				v = $urandom_range(0, 31);
			write_reg(REG_ROTATION, v);

			pick = $urandom_range(0, 9);
			if (pick == 0)      v = '0;
			else if (pick == 1) v = '1;
			else                v = $urandom;
			write_reg(REG_GRID, v);

			v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256);
			write_reg(REG_DEPTH, v);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, $urandom);
			cfg_valid <= 1'b0;

			tx_quiet = (p == 2 || p == 3 || p == 6);
			rx_quiet = (p == 2 || p == 5);
			n_items = PHASE_ITEMS;
			if (p == 3) begin
				n_items = FLOOD_ITEMS;
				hold_go = 1'b1;
			end
			for (j = 0; j < n_items; j++)
				send_step(STEP_W'($urandom_range(0, 31)), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_count == 0 && pending_gates.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/erg_pkg.sv
rtl/core/erg_cell.sv
rtl/core/euclidean_rhythm_step_gate_top.sv
tb/testbench.sv
